/* sv/v3n_pkg.sv */
// Shared widths and payload types for the 3D vector normalization core.
`default_nettype none
package v3n_pkg;

    localparam int COMP_W     = 24;            // component width, Q8.16
    localparam int FRAC_W     = 16;            // fraction bits
    localparam int UNIT_W     = FRAC_W + 2;    // unit component width, Q2.16
    localparam int SQ_W       = 2 * COMP_W;    // one raw square
    localparam int SUM_W      = 2 * COMP_W;    // three squares of magnitudes up to 2^23
    localparam int ROOT_W     = SUM_W / 2;     // square root width
    localparam int SQRT_REM_W = ROOT_W + 2;    // root remainder width
    localparam int QUO_W      = FRAC_W + 1;    // quotient up to and including 1.0
    localparam int DIV_REM_W  = COMP_W + 1;    // divider partial remainder
    localparam int IN_DATA_W  = 3 * COMP_W;
    localparam int OUT_DATA_W = 80;            // 3*18 + 24 = 78, padded to bytes

    typedef logic [COMP_W-1:0] t_comp;

    // Absolute values and signs of the three components.
    typedef struct packed {
        logic [2:0][COMP_W-1:0] mag;
        logic [2:0]             neg;
    } t_mags;

endpackage
`default_nettype wire

/* sv/v3n_square.sv */
// Front end: absolute values, raw squares and their sum over three stages.
`default_nettype none
module v3n_square (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_ce,
    input  wire logic                        i_valid,
    input  wire logic [v3n_pkg::IN_DATA_W-1:0] i_data,
    output logic                             o_valid,
    output v3n_pkg::t_mags                   o_mags,
    output logic [v3n_pkg::SUM_W-1:0]        o_sum
);
    import v3n_pkg::*;

    logic [2:0]            r_valid;
    t_mags                 r_mags1, r_mags2, r_mags3;
    t_mags                 n_mags1;
    logic [2:0][SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0]      r_sum;

    // Split the components and take absolute values.
    always_comb begin
        t_comp v;
        for (int i = 0; i < 3; i++) begin
            v = i_data[i*COMP_W +: COMP_W];
            n_mags1.neg[i] = v[COMP_W-1];
            n_mags1.mag[i] = v[COMP_W-1] ? (~v + t_comp'(1)) : v;
        end
    end

    // Valid bits advance with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ce) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Payload stages: magnitudes, then squares, then their sum.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mags1 <= n_mags1;
            r_mags2 <= r_mags1;
            r_mags3 <= r_mags2;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_mags1.mag[i] * r_mags1.mag[i];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_valid = r_valid[2];
    assign o_mags  = r_mags3;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

/* sv/v3n_sqrt.sv */
// Pipelined floor square root, one root bit per register stage.
`default_nettype none
module v3n_sqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_ce,
    input  wire logic                     i_valid,
    input  v3n_pkg::t_mags                i_mags,
    input  wire logic [v3n_pkg::SUM_W-1:0] i_sum,
    output logic                          o_valid,
    output v3n_pkg::t_mags                o_mags,
    output logic [v3n_pkg::ROOT_W-1:0]    o_root
);
    import v3n_pkg::*;

    logic [ROOT_W:1]                      r_valid;
    t_mags                                r_mags [1:ROOT_W];
    logic [SUM_W-1:0]                     r_rad  [1:ROOT_W];
    logic [SQRT_REM_W-1:0]                r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0]                    r_root [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                  stg_valid;
        t_mags                 stg_mags;
        logic [SUM_W-1:0]      stg_rad;
        logic [SQRT_REM_W-1:0] stg_rem;
        logic [ROOT_W-1:0]     stg_root;
        logic [SQRT_REM_W-1:0] n_rem_pre;
        logic [SQRT_REM_W-1:0] n_trial;
        logic                  n_take;

        // The first stage takes its operands straight from the front end.
        if (k == 0) begin : g_first
            assign stg_valid = i_valid;
            assign stg_mags  = i_mags;
            assign stg_rad   = i_sum;
            assign stg_rem   = '0;
            assign stg_root  = '0;
        end else begin : g_next
            assign stg_valid = r_valid[k];
            assign stg_mags  = r_mags[k];
            assign stg_rad   = r_rad[k];
            assign stg_rem   = r_rem[k];
            assign stg_root  = r_root[k];
        end

        // Bring down the next radicand bit pair and try the new root bit.
        always_comb begin
            n_rem_pre = {stg_rem[SQRT_REM_W-3:0], stg_rad[2*(ROOT_W-1-k) +: 2]};
            n_trial   = {stg_root, 2'b01};
            n_take    = (n_rem_pre >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_valid[k+1] <= stg_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_mags[k+1] <= stg_mags;
                r_rad[k+1]  <= stg_rad;
                r_rem[k+1]  <= n_take ? (n_rem_pre - n_trial) : n_rem_pre;
                r_root[k+1] <= {stg_root[ROOT_W-2:0], n_take};
            end
        end
    end

    assign o_valid = r_valid[ROOT_W];
    assign o_mags  = r_mags[ROOT_W];
    assign o_root  = r_root[ROOT_W];

endmodule
`default_nettype wire

/* sv/v3n_div.sv */
// Three-lane pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module v3n_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_ce,
    input  wire logic                        i_valid,
    input  v3n_pkg::t_mags                   i_mags,
    input  wire logic [v3n_pkg::ROOT_W-1:0]  i_len,
    output logic                             o_valid,
    output logic [2:0]                       o_neg,
    output logic [v3n_pkg::ROOT_W-1:0]       o_len,
    output logic [2:0][v3n_pkg::QUO_W-1:0]   o_quo
);
    import v3n_pkg::*;

    logic [QUO_W:1]                    r_valid;
    logic [2:0]                        r_neg  [1:QUO_W];
    logic [ROOT_W-1:0]                 r_len  [1:QUO_W];
    logic [2:0][DIV_REM_W-1:0]         r_rem  [1:QUO_W];
    logic [2:0][QUO_W-1:0]             r_quo  [1:QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic                      stg_valid;
        logic [2:0]                stg_neg;
        logic [ROOT_W-1:0]         stg_len;
        logic [2:0][DIV_REM_W-1:0] stg_rem;
        logic [2:0][QUO_W-1:0]     stg_quo;
        logic [2:0]                stg_bit;
        logic [2:0][DIV_REM_W-1:0] n_pre;
        logic [2:0]                n_take;

        // The upper numerator bits (magnitude shifted left, upper part) start
        // as the remainder; they stay below the divisor since
        // |component| <= length. The numerator bit for the first step is the
        // magnitude's low bit, and zeros follow.
        if (j == 0) begin : g_first
            assign stg_valid = i_valid;
            assign stg_neg   = i_mags.neg;
            assign stg_len   = i_len;
            assign stg_quo   = '0;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign stg_rem[i] = DIV_REM_W'(i_mags.mag[i][COMP_W-1:1]);
                assign stg_bit[i] = i_mags.mag[i][0];
            end
        end else begin : g_next
            assign stg_valid = r_valid[j];
            assign stg_neg   = r_neg[j];
            assign stg_len   = r_len[j];
            assign stg_rem   = r_rem[j];
            assign stg_quo   = r_quo[j];
            assign stg_bit   = '0;
        end

        // Shift in the numerator bit and compare against the divisor.
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_pre[i]  = {stg_rem[i][DIV_REM_W-2:0], stg_bit[i]};
                n_take[i] = (n_pre[i] >= {1'b0, stg_len});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_ce) begin
                r_valid[j+1] <= stg_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_neg[j+1] <= stg_neg;
                r_len[j+1] <= stg_len;
                for (int i = 0; i < 3; i++) begin
                    r_rem[j+1][i] <= n_take[i] ? (n_pre[i] - {1'b0, stg_len}) : n_pre[i];
                    r_quo[j+1][i] <= {stg_quo[i][QUO_W-2:0], n_take[i]};
                end
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_neg   = r_neg[QUO_W];
    assign o_len   = r_len[QUO_W];
    assign o_quo   = r_quo[QUO_W];

endmodule
`default_nettype wire

/* sv/vector3_normalize_core.sv */
// Pipeline from input transfer to output: squares and sum, the root (one
// bit per stage), the divides (one bit per stage), then 1 output register.
// Throughput: one vector per cycle; the whole pipeline holds while the output
// register is full and the downstream side is not ready.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module vector3_normalize_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: comp_x [23:0], comp_y [47:24], comp_z [71:48]
    input  wire logic [v3n_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: unit_x [17:0], unit_y [35:18], unit_z [53:36], magnitude [77:54], zeros
    output logic [v3n_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: zero_vector [0]
    output logic                               m_axis_tuser
);
    import v3n_pkg::*;

    logic                   ce;
    logic                   sq_valid, rt_valid, dv_valid;
    t_mags                  sq_mags, rt_mags;
    logic [SUM_W-1:0]       sq_sum;
    logic [ROOT_W-1:0]      rt_root, dv_len;
    logic [2:0]             dv_neg;
    logic [2:0][QUO_W-1:0]  dv_quo;
    logic [2:0][UNIT_W-1:0] n_unit;
    logic                   n_zero;

    logic                   r_out_valid;
    logic [2:0][UNIT_W-1:0] r_unit;
    logic [COMP_W-1:0]      r_mag;
    logic                   r_zero;

    // The pipeline advances whenever the output register can take a new item.
    assign ce            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = ce;

    v3n_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_valid (sq_valid),
        .o_mags  (sq_mags),
        .o_sum   (sq_sum)
    );

    v3n_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_valid),
        .i_mags  (sq_mags),
        .i_sum   (sq_sum),
        .o_valid (rt_valid),
        .o_mags  (rt_mags),
        .o_root  (rt_root)
    );

    v3n_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (rt_valid),
        .i_mags  (rt_mags),
        .i_len   (rt_root),
        .o_valid (dv_valid),
        .o_neg   (dv_neg),
        .o_len   (dv_len),
        .o_quo   (dv_quo)
    );

    // Apply signs; a zero length forces zero components.
    always_comb begin
        logic [UNIT_W-1:0] q;
        n_zero = (dv_len == '0);
        for (int i = 0; i < 3; i++) begin
            q = UNIT_W'(dv_quo[i]);
            if (n_zero) begin
                n_unit[i] = '0;
            end else if (dv_neg[i]) begin
                n_unit[i] = ~q + UNIT_W'(1);
            end else begin
                n_unit[i] = q;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_unit <= n_unit;
            r_mag  <= COMP_W'(dv_len);
            r_zero <= n_zero;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_mag, r_unit[2], r_unit[1], r_unit[0]};
    assign m_axis_tuser  = r_zero;

endmodule
`default_nettype wire
